@@ design/xxh_pkg.sv @@
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;
  localparam logic [4:0] TAIL_MASK = 5'h1F;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } q_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WAIT,
    ST_F_MUL1, ST_F_MUL2, ST_F_WR,
    ST_FIN, ST_CONV,
    ST_M_MUL1, ST_M_MUL2, ST_M_MUL3, ST_M_ADD,
    ST_ADDLEN, ST_TAIL,
    ST_T8_MUL1, ST_T8_MUL2, ST_T8_MUL3, ST_T8_ADD,
    ST_T4_MUL1, ST_T4_MUL2, ST_T4_ADD,
    ST_T1_MUL1, ST_T1_MUL2, ST_T1_WR,
    ST_AV1, ST_AV2, ST_AV3, ST_OUT
  } state_e;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

endpackage
`default_nettype wire

@@ design/xxh_front.sv @@
`default_nettype none
module xxh_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [63:0]      data_word_i,
  input  wire logic [3:0]       byte_count_i,
  input  wire logic             last_i,
  output logic                  item_valid_o,
  output xxh_pkg::q_item_t      item_o,
  input  wire logic             pop_i
);

  xxh_pkg::q_item_t mem_q [2];
  xxh_pkg::q_item_t wr_item;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic [3:0] cnt;
  logic [63:0] masked;
  logic       push;

  // A short count only counts on the last word; above eight means eight.
  always_comb begin
    if (!last_i || (byte_count_i > 4'd8)) begin
      cnt = 4'd8;
    end else begin
      cnt = byte_count_i;
    end
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (4'(b) < cnt) ? data_word_i[b*8 +: 8] : 8'd0;
    end
  end

  assign wr_item = '{word: masked, count: cnt, last: last_i};
  assign in_ready_o = (fill_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i && item_valid_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !(pop_i && item_valid_o)) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && pop_i && item_valid_o) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

endmodule
`default_nettype wire

@@ design/xxh_mul.sv @@
`default_nettype none
module xxh_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);

  logic [63:0] a_q, b_q, prod_q, prod_d;
  logic [1:0]  ph_q, ph_d;
  logic        done_q, done_d;
  logic [31:0] ma, mb;
  logic [63:0] p;

  // Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
  always_comb begin
    ma = a_q[31:0];
    mb = b_q[31:0];
    case (ph_q)
      2'd2: begin
        mb = b_q[63:32];
      end
      2'd3: begin
        ma = a_q[63:32];
      end
      default: begin
      end
    endcase
  end

  assign p = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    prod_d = prod_q;
    ph_d   = ph_q;
    done_d = 1'b0;
    case (ph_q)
      2'd1: begin
        prod_d = p;
        ph_d   = 2'd2;
      end
      2'd2: begin
        prod_d = prod_q + {p[31:0], 32'd0};
        ph_d   = 2'd3;
      end
      2'd3: begin
        prod_d = prod_q + {p[31:0], 32'd0};
        ph_d   = 2'd0;
        done_d = 1'b1;
      end
      default: begin
        if (start_i) begin
          ph_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i && (ph_q == 2'd0)) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ design/xxh_back.sv @@
`default_nettype none
module xxh_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [63:0]      seed_i,
  input  wire logic             item_valid_i,
  input  wire xxh_pkg::q_item_t item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [63:0]           hash_o
);

  xxh_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [63:0] buf_q [4];
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic        buf_we;
  logic [1:0]  buf_wa;
  logic [4:0]  bb_q, bb_d;
  logic [63:0] len_q, len_d;
  logic        sd_q, sd_d;
  logic        last_q, last_d;
  logic [63:0] h_q, h_d;
  logic [1:0]  idx_q, idx_d;
  logic [4:0]  rem_q, rem_d;
  logic [4:0]  pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;

  logic        mul_start;
  logic [63:0] mul_a, mul_b, prod;
  logic        mul_done;
  logic [5:0]  sum;
  logic        fold;
  logic [1:0]  rd_addr;
  logic [63:0] rd_word, lane_rd, tail_byte, ptmp;
  logic        out_free;

  xxh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign sum      = {1'b0, bb_q} + {2'b00, item_i.count};
  assign fold     = sum[5];
  assign out_free = !out_valid_q || out_ready_i;
  assign rd_addr  = (state_q == xxh_pkg::ST_F_MUL1) ? idx_q : pos_q[4:3];
  assign rd_word  = buf_q[rd_addr];
  assign lane_rd  = lane_q[idx_q];
  assign tail_byte = {56'd0, rd_word[{pos_q[2:0], 3'b000} +: 8]};

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      xxh_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          if (fold) begin
            state_d = xxh_pkg::ST_F_MUL1;
          end else if (item_i.last) begin
            state_d = xxh_pkg::ST_FIN;
          end
        end
      end
      xxh_pkg::ST_WAIT: begin
        if (mul_done) begin
          state_d = ret_q;
        end
      end
      xxh_pkg::ST_F_MUL1: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_F_MUL2;
      end
      xxh_pkg::ST_F_MUL2: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_F_WR;
      end
      xxh_pkg::ST_F_WR: begin
        if (idx_q != 2'd3) begin
          state_d = xxh_pkg::ST_F_MUL1;
        end else if (last_q) begin
          state_d = xxh_pkg::ST_FIN;
        end else begin
          state_d = xxh_pkg::ST_IDLE;
        end
      end
      xxh_pkg::ST_FIN: begin
        state_d = sd_q ? xxh_pkg::ST_CONV : xxh_pkg::ST_ADDLEN;
      end
      xxh_pkg::ST_CONV: begin
        if (idx_q == 2'd3) begin
          state_d = xxh_pkg::ST_M_MUL1;
        end
      end
      xxh_pkg::ST_M_MUL1: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_M_MUL2;
      end
      xxh_pkg::ST_M_MUL2: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_M_MUL3;
      end
      xxh_pkg::ST_M_MUL3: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_M_ADD;
      end
      xxh_pkg::ST_M_ADD: begin
        state_d = (idx_q == 2'd3) ? xxh_pkg::ST_ADDLEN : xxh_pkg::ST_M_MUL1;
      end
      xxh_pkg::ST_ADDLEN: begin
        state_d = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_TAIL: begin
        if (rem_q >= 5'd8) begin
          state_d = xxh_pkg::ST_T8_MUL1;
        end else if (rem_q >= 5'd4) begin
          state_d = xxh_pkg::ST_T4_MUL1;
        end else if (rem_q != 5'd0) begin
          state_d = xxh_pkg::ST_T1_MUL1;
        end else begin
          state_d = xxh_pkg::ST_AV1;
        end
      end
      xxh_pkg::ST_T8_MUL1: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T8_MUL2;
      end
      xxh_pkg::ST_T8_MUL2: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T8_MUL3;
      end
      xxh_pkg::ST_T8_MUL3: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T8_ADD;
      end
      xxh_pkg::ST_T8_ADD: begin
        state_d = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_T4_MUL1: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T4_MUL2;
      end
      xxh_pkg::ST_T4_MUL2: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T4_ADD;
      end
      xxh_pkg::ST_T4_ADD: begin
        state_d = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_T1_MUL1: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T1_MUL2;
      end
      xxh_pkg::ST_T1_MUL2: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_T1_WR;
      end
      xxh_pkg::ST_T1_WR: begin
        state_d = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_AV1: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_AV2;
      end
      xxh_pkg::ST_AV2: begin
        state_d = xxh_pkg::ST_WAIT;
        ret_d   = xxh_pkg::ST_AV3;
      end
      xxh_pkg::ST_AV3: begin
        state_d = xxh_pkg::ST_OUT;
      end
      xxh_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = xxh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = xxh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    buf_we    = 1'b0;
    buf_wa    = bb_q[4:3];
    bb_d      = bb_q;
    len_d     = len_q;
    sd_d      = sd_q;
    last_d    = last_q;
    h_d       = h_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    hash_d    = hash_q;
    ptmp      = '0;
    lane_d    = lane_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      xxh_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          buf_we = 1'b1;
          len_d  = len_q + {60'd0, item_i.count};
          last_d = item_i.last;
          idx_d  = 2'd0;
          bb_d   = fold ? 5'd0 : sum[4:0];
          if (fold && !sd_q) begin
            lane_d[0] = seed_i + xxh_pkg::P1 + xxh_pkg::P2;
            lane_d[1] = seed_i + xxh_pkg::P2;
            lane_d[2] = seed_i;
            lane_d[3] = seed_i - xxh_pkg::P1;
            sd_d      = 1'b1;
          end
        end
      end
      xxh_pkg::ST_F_MUL1: begin
        mul_start = 1'b1;
        mul_a     = rd_word;
        mul_b     = xxh_pkg::P2;
      end
      xxh_pkg::ST_F_MUL2: begin
        mul_start = 1'b1;
        mul_a     = xxh_pkg::rotl64(lane_rd + prod, 31);
        mul_b     = xxh_pkg::P1;
      end
      xxh_pkg::ST_F_WR: begin
        lane_d[idx_q] = prod;
        idx_d         = idx_q + 2'd1;
      end
      xxh_pkg::ST_FIN: begin
        idx_d = 2'd0;
        h_d   = sd_q ? 64'd0 : (seed_i + xxh_pkg::P5);
      end
      xxh_pkg::ST_CONV: begin
        case (idx_q)
          2'd0: ptmp = xxh_pkg::rotl64(lane_rd, 1);
          2'd1: ptmp = xxh_pkg::rotl64(lane_rd, 7);
          2'd2: ptmp = xxh_pkg::rotl64(lane_rd, 12);
          default: ptmp = xxh_pkg::rotl64(lane_rd, 18);
        endcase
        h_d   = h_q + ptmp;
        idx_d = idx_q + 2'd1;
      end
      xxh_pkg::ST_M_MUL1: begin
        mul_start = 1'b1;
        mul_a     = lane_rd;
        mul_b     = xxh_pkg::P2;
      end
      xxh_pkg::ST_M_MUL2, xxh_pkg::ST_T8_MUL2: begin
        mul_start = 1'b1;
        mul_a     = xxh_pkg::rotl64(prod, 31);
        mul_b     = xxh_pkg::P1;
      end
      xxh_pkg::ST_M_MUL3: begin
        mul_start = 1'b1;
        mul_a     = h_q ^ prod;
        mul_b     = xxh_pkg::P1;
      end
      xxh_pkg::ST_M_ADD: begin
        h_d   = prod + xxh_pkg::P4;
        idx_d = idx_q + 2'd1;
      end
      xxh_pkg::ST_ADDLEN: begin
        h_d   = h_q + len_q;
        rem_d = bb_q & xxh_pkg::TAIL_MASK;
        pos_d = 5'd0;
      end
      xxh_pkg::ST_T8_MUL1: begin
        mul_start = 1'b1;
        mul_a     = rd_word;
        mul_b     = xxh_pkg::P2;
      end
      xxh_pkg::ST_T8_MUL3: begin
        mul_start = 1'b1;
        mul_a     = xxh_pkg::rotl64(h_q ^ prod, 27);
        mul_b     = xxh_pkg::P1;
      end
      xxh_pkg::ST_T8_ADD: begin
        h_d   = prod + xxh_pkg::P4;
        pos_d = pos_q + 5'd8;
        rem_d = rem_q - 5'd8;
      end
      xxh_pkg::ST_T4_MUL1: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, rd_word[31:0]};
        mul_b     = xxh_pkg::P1;
      end
      xxh_pkg::ST_T4_MUL2: begin
        mul_start = 1'b1;
        mul_a     = xxh_pkg::rotl64(h_q ^ prod, 23);
        mul_b     = xxh_pkg::P2;
      end
      xxh_pkg::ST_T4_ADD: begin
        h_d   = prod + xxh_pkg::P3;
        pos_d = pos_q + 5'd4;
        rem_d = rem_q - 5'd4;
      end
      xxh_pkg::ST_T1_MUL1: begin
        mul_start = 1'b1;
        mul_a     = tail_byte;
        mul_b     = xxh_pkg::P5;
      end
      xxh_pkg::ST_T1_MUL2: begin
        mul_start = 1'b1;
        mul_a     = xxh_pkg::rotl64(h_q ^ prod, 11);
        mul_b     = xxh_pkg::P1;
      end
      xxh_pkg::ST_T1_WR: begin
        h_d   = prod;
        pos_d = pos_q + 5'd1;
        rem_d = rem_q - 5'd1;
      end
      xxh_pkg::ST_AV1: begin
        mul_start = 1'b1;
        mul_a     = h_q ^ (h_q >> 33);
        mul_b     = xxh_pkg::P2;
      end
      xxh_pkg::ST_AV2: begin
        mul_start = 1'b1;
        mul_a     = prod ^ (prod >> 29);
        mul_b     = xxh_pkg::P3;
      end
      xxh_pkg::ST_AV3: begin
        h_d = prod ^ (prod >> 32);
      end
      xxh_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hash_d      = h_q;
          bb_d        = 5'd0;
          len_d       = 64'd0;
          sd_d        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xxh_pkg::ST_IDLE;
      ret_q       <= xxh_pkg::ST_IDLE;
      bb_q        <= 5'd0;
      len_q       <= 64'd0;
      sd_q        <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      bb_q        <= bb_d;
      len_q       <= len_d;
      sd_q        <= sd_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    hash_q <= hash_d;
    lane_q <= lane_d;
    if (buf_we) begin
      buf_q[buf_wa] <= item_i.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == xxh_pkg::ST_IDLE))
    else $error("item taken outside the idle state");

  a_bb_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xxh_pkg::ST_IDLE) |-> (bb_q[2:0] == 3'd0))
    else $error("stripe buffer fill not word aligned between items");

  a_word_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xxh_pkg::ST_T4_MUL1) |-> (pos_q[2:0] == 3'd0))
    else $error("four-byte step off a word boundary");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == xxh_pkg::ST_OUT) && out_free) |=> ((bb_q == 5'd0) && !sd_q && out_valid_q))
    else $error("message state not cleared after the result");

endmodule
`default_nettype wire

@@ design/xxh64_stream_hash_core.sv @@
`default_nettype none
// A word that does not complete a 32-byte stripe is only stored in the stripe buffer;
// a word that completes one is folded into the four lanes, each 64-bit multiply going
// through the shared three-step 32 by 32 multiplier (two multiplies per lane).
// After the last word come the fold when that word completes a stripe, the lane
// convergence and one merge per lane once a stripe was folded, the length add, the
// 8-byte, 4-byte and single-byte tail steps, and the avalanche before the result.
// Reset clears the seed to zero, the input queue, stripe fill, length and seeded flag.
module xxh64_stream_hash_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // data_word [63:0], byte_count [67:64], zero fill
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // hash_value [63:0]
);

  logic [63:0]      seed_q;
  logic             item_valid;
  logic             pop;
  xxh_pkg::q_item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 64'd0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  xxh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_word_i  (s_axis_tdata[63:0]),
    .byte_count_i (s_axis_tdata[67:64]),
    .last_i       (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  xxh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .hash_o       (m_axis_tdata)
  );

endmodule
`default_nettype wire
